// File: design/gpbs_pkg.sv
// Shared types and constants of the glyph-to-pixel byte stream core.
`default_nettype none

package gpbs_pkg;

  localparam int GLYPH_COUNT_DEF   = 256;
  localparam int GLYPH_COLUMNS_DEF = 5;
  localparam int GLYPH_ROWS        = 8;
  localparam int HEADER_BYTES      = 11;
  localparam int DIM_MAX           = 256;

  localparam logic [8:0] SCREEN_WIDTH_RESET  = 9'd128;
  localparam logic [8:0] SCREEN_HEIGHT_RESET = 9'd160;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
  localparam logic [7:0] DATA_ZERO        = 8'h00;
  localparam logic       FLAG_DATA        = 1'b1;
  localparam logic       FLAG_COMMAND     = 1'b0;

  // Positions within the window set-up sequence.
  localparam logic [3:0] HDR_COLUMN_CMD = 4'd0;
  localparam logic [3:0] HDR_X_START    = 4'd2;
  localparam logic [3:0] HDR_X_END      = 4'd4;
  localparam logic [3:0] HDR_ROW_CMD    = 4'd5;
  localparam logic [3:0] HDR_Y_START    = 4'd7;
  localparam logic [3:0] HDR_Y_END      = 4'd9;
  localparam logic [3:0] HDR_WRITE_CMD  = 4'd10;

  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    REQ_FONT_WRITE = 2'd0,
    REQ_DRAW       = 2'd1,
    REQ_PULL       = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    ST_EMIT     = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_REJECTED = 3'd2,
    ST_BUSY     = 3'd3,
    ST_IDLE     = 3'd4
  } status_t;

endpackage

`default_nettype wire

// File: design/glyph_to_pixel_byte_stream_core.sv
// Top level: font store, draw-request checker and panel byte stream sequencer.
`default_nettype none

// Renders one scaled 5x8 glyph cell into the panel byte stream. Font writes,
// draw requests and byte pulls arrive on the slave stream; each draw and pull gives
// one word on the master stream, and font writes give none. One request is taken
// every cycle while the output side keeps up; a word passes through the synchronous
// read of the font memory and then through the output register. The font memory
// needs no clearing pass after reset, so requests are taken as soon as reset ends.
module glyph_to_pixel_byte_stream_core
  import gpbs_pkg::*;
#(
  parameter int GLYPH_COUNT   = GLYPH_COUNT_DEF,
  parameter int GLYPH_COLUMNS = GLYPH_COLUMNS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [8:0]   cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // font_index, font_byte, pos_x, pos_y, char_code, fg_color, bg_color, scale
  input  wire logic [103:0] s_tdata,
  // req_type
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_byte
  output logic [7:0]        m_tdata,
  // status, is_data
  output logic [3:0]        m_tuser,
  output logic              m_tlast
);

  localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_COLUMNS;
  localparam int AW         = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;
  localparam int COL_W      = $clog2(GLYPH_COLUMNS + 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_COLUMNS);
  localparam logic [2:0]       LAST_ROW = 3'(GLYPH_ROWS - 1);

  // Input fields.
  logic [10:0]        font_index;
  logic [7:0]         font_byte;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [7:0]         char_code;
  logic [15:0]        fg_color;
  logic [15:0]        bg_color;
  logic [7:0]         scale;
  req_type_t          req_type;

  assign font_index = s_tdata[10:0];
  assign font_byte  = s_tdata[18:11];
  assign pos_x      = s_tdata[34:19];
  assign pos_y      = s_tdata[50:35];
  assign char_code  = s_tdata[58:51];
  assign fg_color   = s_tdata[74:59];
  assign bg_color   = s_tdata[90:75];
  assign scale      = s_tdata[98:91];
  assign req_type   = req_type_t'(s_tuser);

  // Configuration.
  logic [8:0] screen_width;
  logic [8:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state and latched request.
  logic             busy;
  logic [3:0]       header_step;
  logic [2:0]       glyph_row;
  logic [7:0]       row_repeat;
  logic [COL_W-1:0] glyph_col;
  logic [7:0]       col_repeat;
  logic             low_half;
  logic [7:0]       req_x;
  logic [7:0]       req_x1;
  logic [7:0]       req_y;
  logic [7:0]       req_y1;
  logic [11:0]      req_base;
  logic [15:0]      req_fg;
  logic [15:0]      req_bg;
  logic [7:0]       req_scale;

  // Pipeline stage, registered alongside the font read, ahead of the output register.
  logic       p1_valid;
  status_t    p1_status;
  logic [7:0] p1_byte;
  logic       p1_is_data;
  logic       p1_last;
  logic       p1_pixel;
  logic       p1_spacing;
  logic [2:0] p1_row;
  logic [7:0] p1_fg_byte;
  logic [7:0] p1_bg_byte;
  logic [7:0] font_q;

  logic out_free;
  logic s_acc;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !p1_valid || out_free;
  assign s_acc    = s_tvalid && s_tready;

  // Draw request check.
  logic [8:0]         width_eff;
  logic [8:0]         height_eff;
  logic [11:0]        cell_w;
  logic [11:0]        cell_h;
  logic signed [17:0] x_end;
  logic signed [17:0] y_end;
  logic               draw_ok;

  always_comb begin
    width_eff  = (screen_width > 9'(DIM_MAX)) ? 9'(DIM_MAX) : screen_width;
    height_eff = (screen_height > 9'(DIM_MAX)) ? 9'(DIM_MAX) : screen_height;
    cell_w     = 12'(scale) * 12'(GLYPH_COLUMNS + 1);
    cell_h     = 12'(scale) * 12'(GLYPH_ROWS);
    x_end      = 18'(pos_x) + $signed(18'(cell_w)) - 18'sd1;
    y_end      = 18'(pos_y) + $signed(18'(cell_h)) - 18'sd1;
    draw_ok    = (scale != 8'd0) && !pos_x[15] && !pos_y[15] &&
                 ({1'b0, char_code} < 9'(GLYPH_COUNT)) &&
                 (x_end < $signed(18'(width_eff))) &&
                 (y_end < $signed(18'(height_eff)));
  end

  // Pixel sequencing helpers.
  logic [8:0]  col_rep_inc;
  logic [8:0]  row_rep_inc;
  logic        pix_last;
  logic        in_header;
  logic [7:0]  hdr_byte;
  logic        hdr_is_data;
  logic [11:0] rd_addr_full;
  logic [11:0] wr_addr_full;
  logic        font_we;
  logic        font_re;
  logic        pull_go;
  logic        draw_go;

  always_comb begin
    col_rep_inc = {1'b0, col_repeat} + 9'd1;
    row_rep_inc = {1'b0, row_repeat} + 9'd1;
    pix_last    = (glyph_row == LAST_ROW) && (row_rep_inc == {1'b0, req_scale}) &&
                  (glyph_col == LAST_COL) && (col_rep_inc == {1'b0, req_scale}) &&
                  low_half;
    in_header   = header_step < 4'(HEADER_BYTES);
    hdr_is_data = FLAG_DATA;
    case (header_step)
      HDR_COLUMN_CMD: begin
        hdr_byte    = CMD_COLUMN_SET;
        hdr_is_data = FLAG_COMMAND;
      end
      HDR_X_START: hdr_byte = req_x;
      HDR_X_END:   hdr_byte = req_x1;
      HDR_ROW_CMD: begin
        hdr_byte    = CMD_ROW_SET;
        hdr_is_data = FLAG_COMMAND;
      end
      HDR_Y_START: hdr_byte = req_y;
      HDR_Y_END:   hdr_byte = req_y1;
      HDR_WRITE_CMD: begin
        hdr_byte    = CMD_MEMORY_WRITE;
        hdr_is_data = FLAG_COMMAND;
      end
      default: hdr_byte = DATA_ZERO;
    endcase
    rd_addr_full = req_base + 12'(glyph_col);
    wr_addr_full = {1'b0, font_index};
    pull_go      = s_acc && (req_type == REQ_PULL) && busy;
    draw_go      = s_acc && (req_type == REQ_DRAW) && !busy && draw_ok;
    font_we      = s_acc && (req_type == REQ_FONT_WRITE) &&
                   (wr_addr_full < 12'(FONT_DEPTH));
    font_re      = pull_go && !in_header && (glyph_col != LAST_COL);
  end

  // Font store: one write port, one registered read port.
  logic [7:0] font_mem [FONT_DEPTH];

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[wr_addr_full[AW-1:0]] <= font_byte;
    end
    if (font_re) begin
      font_q <= font_mem[rd_addr_full[AW-1:0]];
    end
  end

  // Request handling and state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      header_step <= '0;
      glyph_row   <= '0;
      row_repeat  <= '0;
      glyph_col   <= '0;
      col_repeat  <= '0;
      low_half    <= 1'b0;
      p1_valid    <= 1'b0;
    end else begin
      if (p1_valid && out_free) begin
        p1_valid <= 1'b0;
      end
      if (s_acc) begin
        p1_pixel   <= 1'b0;
        p1_byte    <= DATA_ZERO;
        p1_is_data <= 1'b0;
        p1_last    <= 1'b0;
        case (req_type)
          REQ_DRAW: begin
            p1_valid <= 1'b1;
            if (busy) begin
              p1_status <= ST_BUSY;
            end else if (!draw_ok) begin
              p1_status <= ST_REJECTED;
            end else begin
              p1_status   <= ST_ACCEPTED;
              busy        <= 1'b1;
              header_step <= '0;
              glyph_row   <= '0;
              row_repeat  <= '0;
              glyph_col   <= '0;
              col_repeat  <= '0;
              low_half    <= 1'b0;
              req_x       <= pos_x[7:0];
              req_x1      <= x_end[7:0];
              req_y       <= pos_y[7:0];
              req_y1      <= y_end[7:0];
              req_base    <= 12'(char_code) * 12'(GLYPH_COLUMNS);
              req_fg      <= fg_color;
              req_bg      <= bg_color;
              req_scale   <= scale;
            end
          end
          REQ_PULL: begin
            p1_valid <= 1'b1;
            if (!busy) begin
              p1_status <= ST_IDLE;
            end else if (in_header) begin
              p1_status   <= ST_EMIT;
              p1_byte     <= hdr_byte;
              p1_is_data  <= hdr_is_data;
              header_step <= header_step + 4'd1;
            end else begin
              p1_status  <= ST_EMIT;
              p1_is_data <= FLAG_DATA;
              p1_pixel   <= 1'b1;
              p1_spacing <= glyph_col == LAST_COL;
              p1_row     <= glyph_row;
              p1_last    <= pix_last;
              p1_fg_byte <= low_half ? req_fg[7:0] : req_fg[15:8];
              p1_bg_byte <= low_half ? req_bg[7:0] : req_bg[15:8];
              if (!low_half) begin
                low_half <= 1'b1;
              end else begin
                low_half <= 1'b0;
                if (col_rep_inc < {1'b0, req_scale}) begin
                  col_repeat <= col_rep_inc[7:0];
                end else begin
                  col_repeat <= '0;
                  if (glyph_col != LAST_COL) begin
                    glyph_col <= glyph_col + COL_W'(1);
                  end else begin
                    glyph_col <= '0;
                    if (row_rep_inc < {1'b0, req_scale}) begin
                      row_repeat <= row_rep_inc[7:0];
                    end else begin
                      row_repeat <= '0;
                      if (glyph_row != LAST_ROW) begin
                        glyph_row <= glyph_row + 3'd1;
                      end else begin
                        glyph_row   <= '0;
                        header_step <= '0;
                        busy        <= 1'b0;
                      end
                    end
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Output register; pixel words pick their color from the font column read.
  logic       pix_set;
  logic [7:0] pix_byte;

  always_comb begin
    pix_set  = font_q[p1_row] && !p1_spacing;
    pix_byte = pix_set ? p1_fg_byte : p1_bg_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (out_free) begin
        m_tvalid <= p1_valid;
      end
      if (p1_valid && out_free) begin
        m_tdata <= p1_pixel ? pix_byte : p1_byte;
        m_tuser <= {p1_is_data, p1_status};
        m_tlast <= p1_last;
      end
    end
  end

  // A stalled stage must keep the font column it already read.
  a_p1_hold : assert property (@(posedge clk) disable iff (rst)
    (p1_valid && !out_free) |=> (p1_valid && $stable(font_q) && $stable(p1_row)))
    else $error("pipeline stage lost its word while stalled");

  // An accepted draw starts the stream at the window set-up.
  a_draw_start : assert property (@(posedge clk) disable iff (rst)
    draw_go |=> (busy && header_step == '0 && !low_half))
    else $error("accepted draw did not start the byte stream");

  // While idle the sequencer sits at the start of a stream.
  a_idle_clear : assert property (@(posedge clk) disable iff (rst)
    !busy |-> (header_step == '0 && glyph_row == '0 && glyph_col == '0 && !low_half))
    else $error("sequencer counters not cleared while idle");

  // Only an emitted data word may close a stream.
  a_last_word : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser[2:0] == ST_EMIT && m_tuser[3] == FLAG_DATA))
    else $error("end of stream marked on a word that is not pixel data");

endmodule

`default_nettype wire
